// File: hdl/prewitt_gradient_edge_stream_unit_macros.svh
// assertion macros shared by the prewitt gradient rtl
`ifndef PREWITT_GRADIENT_EDGE_STREAM_UNIT_MACROS_SVH
`define PREWITT_GRADIENT_EDGE_STREAM_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PGE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PGE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pge_pkg.sv
// package: constants, register codes and pipeline types for the prewitt gradient unit
`timescale 1ns / 1ps

package pge_pkg;

  // default geometry
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_ROWS_DEF  = 4096;

  // configuration register indexes and reset values
  localparam logic [1:0]  CFG_LINE_WIDTH     = 2'd0;
  localparam logic [1:0]  CFG_EDGE_THRESHOLD = 2'd1;
  localparam logic [10:0] LINE_WIDTH_RESET   = 11'd640;
  localparam logic [14:0] THRESHOLD_RESET    = 15'd1840;

  // angle constants, q12 radians
  localparam logic signed [14:0] PI_Q12      = 15'sd12868;
  localparam logic signed [22:0] HALF_PI_Q12 = 23'sd6434;

  localparam int CORDIC_STEPS = 16;
  localparam int ROOT_W       = 15;

  // atan(2^-i) in q20
  localparam logic signed [22:0] ATAN_Q20 [CORDIC_STEPS] = '{
    23'sd823550, 23'sd486170, 23'sd256879, 23'sd130396,
    23'sd65451,  23'sd32757,  23'sd16383,  23'sd8192,
    23'sd4096,   23'sd2048,   23'sd1024,   23'sd512,
    23'sd256,    23'sd128,    23'sd64,     23'sd32
  };

  // one word in flight through the root and cordic stages
  typedef struct packed {
    logic signed [10:0]       gx;
    logic signed [10:0]       gy;
    logic [29:0]              rem;
    logic [ROOT_W-1:0]        root;
    logic signed [28:0]       x;
    logic signed [28:0]       y;
    logic signed [22:0]       z;
  } calc_t;

endpackage

// File: hdl/prewitt_gradient_edge_stream_unit.sv
// top level: line buffers, 3x3 prewitt window, pipelined square root and cordic
// Usage of the prewitt gradient stream unit.
// Input channel: in_valid / in_stall carry one grey pixel word per accept, in
// raster order; in_frame_start puts the position back to column 0, row 0.
// Output channel: out_valid / out_stall carry one result word for every pixel
// whose 3x3 neighbourhood lies wholly inside the image; border pixels give none.
// Config channel: cfg_valid / cfg_ready (always ready) write line_width (index 0)
// or edge_threshold (index 1); other indexes are ignored. Write only when idle.
// Result path: the window stages, one squaring stage and sixteen cordic stages
// that run alongside the fifteen-step square root, then the output register.
// Throughput: one pixel per cycle unless stalled; line buffers are single-write,
// single-read memories with a forward path for back-to-back same-column access.
// When the receiver stalls a full output word, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears position counters, window, valid bits and restores the registers
// to 640 and 1840; line buffer contents are left as they are.
`timescale 1ns / 1ps

module prewitt_gradient_edge_stream_unit
  import pge_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = $clog2(MAX_ROWS)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_pixel_value,
  input  logic                    in_frame_start,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [10:0]      out_horizontal_gradient,
  output logic signed [10:0]      out_vertical_gradient,
  output logic [14:0]             out_gradient_magnitude,
  output logic signed [14:0]      out_gradient_direction,
  output logic [14:0]             out_edge_strength,
  output logic [COL_W-1:0]        out_centre_column,
  output logic [ROW_W-1:0]        out_centre_row,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [14:0]             cfg_data
);

`include "prewitt_gradient_edge_stream_unit_macros.svh"

  logic adv, acc;

  // configuration registers
  logic [10:0] line_width_r;
  logic [14:0] threshold_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RESET;
      threshold_r  <= THRESHOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LINE_WIDTH:     line_width_r <= cfg_data[10:0];
        CFG_EDGE_THRESHOLD: threshold_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: pipeline moves unless a finished word is held
  logic out_valid_r;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  // raster position
  logic [COL_W-1:0] col_r, col_nxt, col_base, cc;
  logic [ROW_W-1:0] row_r, row_nxt, row_base;
  int               width_eff;
  logic             wrap, emit;

  always_comb begin
    col_base = in_frame_start ? '0 : col_r;
    row_base = in_frame_start ? '0 : row_r;
    cc = (32'(col_base) >= MAX_WIDTH) ? COL_W'(MAX_WIDTH - 1) : col_base;
    if (32'(line_width_r) < 3) width_eff = 3;
    else if (32'(line_width_r) > MAX_WIDTH) width_eff = MAX_WIDTH;
    else width_eff = 32'(line_width_r);
    wrap = (32'(cc) + 1) >= width_eff;
    col_nxt = wrap ? '0 : cc + 1'b1;
    if (wrap && (32'(row_base) < MAX_ROWS - 1)) row_nxt = row_base + 1'b1;
    else row_nxt = row_base;
    emit = (32'(cc) >= 2) && (32'(row_base) >= 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: line buffer read
  logic             s1_valid_r, s1_emit_r, fwd_r;
  logic [COL_W-1:0] s1_addr_r, s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [7:0]       s1_pix_r, up_rd_r, mid_rd_r, fwd_dat_r, up1;
  logic [7:0]       upper_mem [MAX_WIDTH];
  logic [7:0]       middle_mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (acc) begin
      mid_rd_r             <= middle_mem[cc];
      middle_mem[cc]       <= in_pixel_value;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) up_rd_r <= upper_mem[cc];
    if (adv && s1_valid_r) upper_mem[s1_addr_r] <= mid_rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else if (adv) s1_valid_r <= acc;
    if (acc) begin
      s1_addr_r <= cc;
      s1_pix_r  <= in_pixel_value;
      s1_emit_r <= emit;
      s1_col_r  <= cc - 1'b1;
      s1_row_r  <= row_base - 1'b1;
      // same column again right away: upper write still in flight
      fwd_r     <= s1_valid_r && (s1_addr_r == cc);
      fwd_dat_r <= mid_rd_r;
    end
  end

  assign up1 = fwd_r ? fwd_dat_r : up_rd_r;

  // stage 2: window shift
  logic [7:0]       win_r [9];
  logic             s2_valid_r;
  logic [COL_W-1:0] s2_col_r;
  logic [ROW_W-1:0] s2_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r && s1_emit_r;
      if (s1_valid_r) begin
        for (int k = 0; k < 3; k++) begin
          win_r[k*3]   <= win_r[k*3+1];
          win_r[k*3+1] <= win_r[k*3+2];
        end
        win_r[2] <= up1;
        win_r[5] <= mid_rd_r;
        win_r[8] <= s1_pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_col_r <= s1_col_r;
      s2_row_r <= s1_row_r;
    end
  end

  // stage 3: prewitt sums
  logic signed [10:0] gx_c, gy_c, s3_gx_r, s3_gy_r;
  logic               s3_valid_r;
  logic [COL_W-1:0]   s3_col_r;
  logic [ROW_W-1:0]   s3_row_r;

  always_comb begin
    gx_c = '0;
    gy_c = '0;
    for (int k = 0; k < 3; k++) begin
      gx_c = gx_c + $signed({3'b0, win_r[k*3+2]}) - $signed({3'b0, win_r[k*3]});
      gy_c = gy_c + $signed({3'b0, win_r[6+k]}) - $signed({3'b0, win_r[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s3_valid_r <= 1'b0;
    else if (adv) s3_valid_r <= s2_valid_r;
    if (adv) begin
      s3_gx_r  <= gx_c;
      s3_gy_r  <= gy_c;
      s3_col_r <= s2_col_r;
      s3_row_r <= s2_row_r;
    end
  end

  // stage 4: squares and cordic seed
  logic signed [21:0] pxx, pyy;
  logic [21:0]        sqsum;
  logic [10:0]        agx, agy;
  calc_t              seed;

  always_comb begin
    pxx   = s3_gx_r * s3_gx_r;
    pyy   = s3_gy_r * s3_gy_r;
    sqsum = 22'(pxx + pyy);
    agx   = s3_gx_r[10] ? 11'(-s3_gx_r) : s3_gx_r;
    agy   = s3_gy_r[10] ? 11'(-s3_gy_r) : s3_gy_r;
    seed.gx   = s3_gx_r;
    seed.gy   = s3_gy_r;
    seed.rem  = {sqsum, 8'b0};
    seed.root = '0;
    seed.x    = $signed({2'b0, agx, 16'b0});
    seed.y    = $signed({2'b0, agy, 16'b0});
    seed.z    = '0;
  end

  calc_t            cs_r  [CORDIC_STEPS+1];
  logic             cv_r  [CORDIC_STEPS+1];
  logic [COL_W-1:0] ccol_r[CORDIC_STEPS+1];
  logic [ROW_W-1:0] crow_r[CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r[0] <= 1'b0;
    else if (adv) cv_r[0] <= s3_valid_r;
    if (adv) begin
      cs_r[0]   <= seed;
      ccol_r[0] <= s3_col_r;
      crow_r[0] <= s3_row_r;
    end
  end

  // stages 5..20: one cordic step per stage; stages 5..19 also give one root bit each
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    calc_t       nx;
    logic [30:0] trial;

    always_comb begin
      nx    = cs_r[k];
      trial = '0;
      if (k < ROOT_W) begin
        trial = (31'(cs_r[k].root) << (ROOT_W - k)) + (31'(1) << (2 * (ROOT_W - 1 - k)));
        if ({1'b0, cs_r[k].rem} >= trial) begin
          nx.rem  = cs_r[k].rem - trial[29:0];
          nx.root = cs_r[k].root | (ROOT_W'(1) << (ROOT_W - 1 - k));
        end
      end
      if (cs_r[k].y >= 0) begin
        nx.x = cs_r[k].x + (cs_r[k].y >>> k);
        nx.y = cs_r[k].y - (cs_r[k].x >>> k);
        nx.z = cs_r[k].z + ATAN_Q20[k];
      end else begin
        nx.x = cs_r[k].x - (cs_r[k].y >>> k);
        nx.y = cs_r[k].y + (cs_r[k].x >>> k);
        nx.z = cs_r[k].z - ATAN_Q20[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) cv_r[k+1] <= 1'b0;
      else if (adv) cv_r[k+1] <= cv_r[k];
      if (adv) begin
        cs_r[k+1]   <= nx;
        ccol_r[k+1] <= ccol_r[k];
        crow_r[k+1] <= crow_r[k];
      end
    end
  end

  // output stage: angle rounding, quadrant and threshold
  calc_t              fin;
  logic signed [22:0] a_raw, a_clip;
  logic signed [14:0] a15, dir_c;

  always_comb begin
    fin    = cs_r[CORDIC_STEPS];
    a_raw  = (fin.z + 23'sd128) >>> 8;
    if (a_raw < 0) a_clip = '0;
    else if (a_raw > HALF_PI_Q12) a_clip = HALF_PI_Q12;
    else a_clip = a_raw;
    a15 = ((fin.gx == 0) && (fin.gy == 0)) ? '0 : a_clip[14:0];
    if (!fin.gx[10]) dir_c = fin.gy[10] ? 15'(-a15) : a15;
    else dir_c = fin.gy[10] ? 15'(a15 - PI_Q12) : 15'(PI_Q12 - a15);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= cv_r[CORDIC_STEPS];
    if (adv) begin
      out_horizontal_gradient <= fin.gx;
      out_vertical_gradient   <= fin.gy;
      out_gradient_magnitude  <= fin.root;
      out_gradient_direction  <= dir_c;
      out_edge_strength       <= (fin.root > threshold_r) ? fin.root : '0;
      out_centre_column       <= ccol_r[CORDIC_STEPS];
      out_centre_row          <= crow_r[CORDIC_STEPS];
    end
  end

  assign out_valid = out_valid_r;

  // checks
  `PGE_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall,
    "input stalled without a held output word")
  `PGE_ASSERT_NOW(a_edge_is_mag, out_valid && (out_edge_strength != 0),
    out_edge_strength == out_gradient_magnitude, "edge strength differs from magnitude")
  `PGE_ASSERT_NOW(a_zero_grad,
    out_valid && (out_horizontal_gradient == 0) && (out_vertical_gradient == 0),
    (out_gradient_magnitude == 0) && (out_gradient_direction == 0),
    "zero gradient gives nonzero magnitude or direction")
  `PGE_ASSERT_NOW(a_interior, out_valid, (out_centre_column != 0) && (out_centre_row != 0),
    "border pixel reported")
  `PGE_ASSERT_NEXT(a_freeze, out_valid && out_stall && !s3_valid_r && !s2_valid_r,
    !s3_valid_r && !s2_valid_r, "pipeline moved while output held")

endmodule
